// ----- src/assert_macros.svh -----
// Assertion macros for the checker file dfr_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check on the cycle after each edge that sees reset asserted.
`define DFR_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

// ----- src/dfr_pkg.sv -----
// Shared types, codes and the CRC-32 byte update of the packet deframer.
// No dependencies.
`default_nettype none

package dfr_pkg;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_GOOD     = 2'd1;
	localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
	localparam logic [1:0] KIND_BAD_SYNC = 2'd3;

	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_SYNC_THIRD  = 2'd2;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hFF;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hEE;
	localparam logic [7:0] SYNC_THIRD_RST  = 8'hDD;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [7:0]  command_code;
		logic [15:0] payload_length;
	} dfr_result_t;

	// Reflected CRC-32, one byte, eight bit steps.
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/dfr_in_reg.sv -----
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on nothing.
`default_nettype none

module dfr_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

// ----- src/dfr_parser.sv -----
// Frame parser: sync hunt, header capture, payload CRC and frame check.
// Depends on dfr_pkg.
`default_nettype none

module dfr_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       advance,
	input  wire logic [7:0] byte_s1,
	output dfr_pkg::dfr_result_t res
);
	import dfr_pkg::*;

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_SYNC3   = 4'd2,
		PH_CMD     = 4'd3,
		PH_LEN_LO  = 4'd4,
		PH_LEN_HI  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CRC0    = 4'd7,
		PH_CRC1    = 4'd8,
		PH_CRC2    = 4'd9,
		PH_CRC3    = 4'd10
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sync_first_q, sync_second_q, sync_third_q;
	logic [15:0] length_q, length_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [31:0] crc_q, crc_d;
	logic [23:0] crc_rx_q, crc_rx_d;
	logic [15:0] count_inc;
	logic [31:0] crc_next;

	assign count_inc = count_q + 16'd1;
	assign crc_next  = crc_feed(crc_q, byte_s1);

	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		count_d  = count_q;
		cmd_d    = cmd_q;
		crc_d    = crc_q;
		crc_rx_d = crc_rx_q;
		res      = '0;
		case (phase_q)
			PH_SYNC2: begin
				if (byte_s1 == sync_second_q) begin
					phase_d = PH_SYNC3;
				end else begin
					phase_d   = PH_SYNC1;
					res.valid = 1'b1;
					res.kind  = KIND_BAD_SYNC;
				end
			end
			PH_SYNC3: begin
				if (byte_s1 == sync_third_q) begin
					phase_d = PH_CMD;
				end else begin
					phase_d   = PH_SYNC1;
					res.valid = 1'b1;
					res.kind  = KIND_BAD_SYNC;
				end
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				crc_d   = CRC_INIT;
				count_d = '0;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {8'd0, byte_s1};
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = {byte_s1, length_q[7:0]};
				count_d  = '0;
				phase_d  = ({byte_s1, length_q[7:0]} == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d   = crc_next;
				count_d = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_CRC0;
				end
				res.valid          = 1'b1;
				res.kind           = KIND_PAYLOAD;
				res.payload_byte   = byte_s1;
				res.command_code   = cmd_q;
				res.payload_length = length_q;
			end
			PH_CRC0: begin
				crc_rx_d = {16'd0, byte_s1};
				phase_d  = PH_CRC1;
			end
			PH_CRC1: begin
				crc_rx_d = {8'd0, byte_s1, crc_rx_q[7:0]};
				phase_d  = PH_CRC2;
			end
			PH_CRC2: begin
				crc_rx_d = {byte_s1, crc_rx_q[15:0]};
				phase_d  = PH_CRC3;
			end
			PH_CRC3: begin
				phase_d            = PH_SYNC1;
				res.valid          = 1'b1;
				res.kind           = ({byte_s1, crc_rx_q} == ~crc_q) ? KIND_GOOD : KIND_BAD_CRC;
				res.command_code   = cmd_q;
				res.payload_length = length_q;
			end
			default: begin
				// first sync byte, also any phase code without meaning
				if (byte_s1 == sync_first_q) begin
					phase_d = PH_SYNC2;
				end else begin
					phase_d   = PH_SYNC1;
					res.valid = 1'b1;
					res.kind  = KIND_BAD_SYNC;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SYNC1;
			length_q      <= '0;
			count_q       <= '0;
			cmd_q         <= '0;
			crc_q         <= CRC_INIT;
			crc_rx_q      <= '0;
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			sync_third_q  <= SYNC_THIRD_RST;
		end else begin
			if (advance) begin
				phase_q  <= phase_d;
				length_q <= length_d;
				count_q  <= count_d;
				cmd_q    <= cmd_d;
				crc_q    <= crc_d;
				crc_rx_q <= crc_rx_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
					CFG_SYNC_SECOND: sync_second_q <= cfg_data;
					CFG_SYNC_THIRD:  sync_third_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/dfr_out_reg.sv -----
// Result register of the deframer, drives the master-side stream.
// Depends on dfr_pkg.
`default_nettype none

module dfr_out_reg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire dfr_pkg::dfr_result_t res,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic [1:0]       m_tuser
);
	import dfr_pkg::*;

	logic        load;
	logic [31:0] data_s2;
	logic [1:0]  kind_s2;

	assign load = advance && res.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= {res.payload_length, res.command_code, res.payload_byte};
			kind_s2 <= res.kind;
		end
	end

	assign m_tdata = data_s2;
	assign m_tuser = kind_s2;

endmodule

`default_nettype wire

// ----- src/sync_framed_packet_crc32_deframer_unit.sv -----
// Sync-word framed packet deframer with CRC-32 payload check.
// Depends on dfr_pkg, dfr_in_reg, dfr_parser, dfr_out_reg.
//
// Takes one received byte per transfer and sustains one byte per clock while the
// result side does not stall. An accepted byte is held in the input register; the
// byte-wide CRC-32 update and the frame state machine then act on it, and any
// result is loaded into the result register once that register is free. Payload
// bytes come out as kind 0, the last CRC byte gives kind 1 (good) or 2 (CRC
// mismatch), and a wrong sync byte gives kind 3 and restarts the hunt. Header and
// the first three CRC bytes give no result. Sync bytes are to be written through
// the config port only while idle; the block itself does not enforce this.
`default_nettype none

module sync_framed_packet_crc32_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] payload_byte, [15:8] command_code,
	                                    // [31:16] payload_length
	output logic [1:0]       m_tuser    // [1:0] result_kind
);
	import dfr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	dfr_result_t res;

	// parser moves when a byte is held and the result register is free
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	dfr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res       (res)
	);

	dfr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- src/dfr_checker.sv -----
// Port-level checks for the deframer top level, attached by bind.
// Depends on dfr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import dfr_pkg::*;

	logic        res_stalled;
	logic        non_payload;
	logic        bad_sync;
	logic [33:0] res_word;

	assign res_stalled = m_tvalid && !m_tready;
	assign non_payload = m_tvalid && (m_tuser != KIND_PAYLOAD);
	assign bad_sync    = m_tvalid && (m_tuser == KIND_BAD_SYNC);
	assign res_word    = {m_tuser, m_tdata};

	`DFR_ASSERT(a_hold, clk, arst_n, res_stalled |=> m_tvalid && $stable(res_word), "result changed")
	`DFR_ASSERT_IN_RST(a_rst_idle, clk, arst_n, !m_tvalid, "result valid during reset")
	`DFR_ASSERT(a_pbyte_zero, clk, arst_n, non_payload |-> m_tdata[7:0] == '0, "stray payload byte")
	`DFR_ASSERT(a_sync_zero, clk, arst_n, bad_sync |-> m_tdata[31:8] == '0, "sync mismatch header")
	`DFR_ASSERT(a_stall_cause, clk, arst_n, !s_tready |-> res_stalled, "needless input stall")

endmodule

bind sync_framed_packet_crc32_deframer_unit dfr_checker u_dfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/dfr_frame_checker.sv -----
// Scoreboard for the packet deframer: its own deframing state machine and CRC-32,
// fed from observed transfers, checks every result transfer in order.
// Depends on dfr_pkg (result kinds, register indexes, CRC constants).

package dfr_tb_pkg;

	typedef enum logic [3:0] {
		RX_SYNC1, RX_SYNC2, RX_SYNC3, RX_CMD, RX_LEN_LO, RX_LEN_HI,
		RX_PAYLOAD, RX_CRC0, RX_CRC1, RX_CRC2, RX_CRC3
	} deframe_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [7:0]  command_code;
		logic [15:0] payload_length;
	} frame_result_t;

	// Reflected CRC-32, one byte taken LSB first.
	function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ dfr_pkg::CRC_POLY;
		end
		return c;
	endfunction

endpackage

module dfr_frame_checker
	import dfr_tb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // [7:0] payload_byte, [15:8] command_code,
	                                    // [31:16] payload_length
	input  wire logic [1:0]  m_tuser,   // [1:0] result_kind
	input  wire logic        end_check,
	output int               results_due,
	output int               fail_count
);

	logic [7:0]      sync_first, sync_second, sync_third;
	deframe_phase_t  phase;
	logic [15:0]     frame_len;
	logic [15:0]     byte_cnt;
	logic [7:0]      cmd_latch;
	logic [31:0]     crc_acc;
	logic [23:0]     crc_rx;
	frame_result_t   pending_results[$];
	int              errors = 0;

	assign fail_count = errors;

	task automatic report(input string field, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("MISMATCH at %0t: %s got 'h%0h, expected 'h%0h", $time, field, got, want);
	endtask

	// Returns 1 when the byte breaks the sync word; the hunt then restarts.
	function automatic bit sync_step(input logic [7:0] b, input logic [7:0] want,
			input deframe_phase_t nxt);
		if (b == want) begin
			phase = nxt;
			return 1'b0;
		end
		phase = RX_SYNC1;
		return 1'b1;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		frame_result_t r;
		bit            emit;
		logic [31:0]   got;
		r = '0;
		emit = 1'b0;
		case (phase)
			// sync mismatch leaves every other field zero
			RX_SYNC2: begin
				emit = sync_step(b, sync_second, RX_SYNC3);
				r.kind = dfr_pkg::KIND_BAD_SYNC;
			end
			RX_SYNC3: begin
				emit = sync_step(b, sync_third, RX_CMD);
				r.kind = dfr_pkg::KIND_BAD_SYNC;
			end
			RX_CMD: begin
				cmd_latch = b;
				crc_acc = dfr_pkg::CRC_INIT;
				byte_cnt = '0;
				phase = RX_LEN_LO;
			end
			RX_LEN_LO: begin
				frame_len = {8'h00, b};
				phase = RX_LEN_HI;
			end
			RX_LEN_HI: begin
				frame_len[15:8] = b;
				byte_cnt = '0;
				phase = (frame_len == 16'd0) ? RX_CRC0 : RX_PAYLOAD;
			end
			RX_PAYLOAD: begin
				crc_acc = crc32_update(crc_acc, b);
				byte_cnt = byte_cnt + 16'd1;
				if (byte_cnt >= frame_len)
					phase = RX_CRC0;
				emit = 1'b1;
				r.kind = dfr_pkg::KIND_PAYLOAD;
				r.payload_byte = b;
				r.command_code = cmd_latch;
				r.payload_length = frame_len;
			end
			RX_CRC0: begin
				crc_rx = {16'h0000, b};
				phase = RX_CRC1;
			end
			RX_CRC1: begin
				crc_rx[15:8] = b;
				phase = RX_CRC2;
			end
			RX_CRC2: begin
				crc_rx[23:16] = b;
				phase = RX_CRC3;
			end
			RX_CRC3: begin
				got = {b, crc_rx};
				emit = 1'b1;
				r.kind = (got == ~crc_acc) ? dfr_pkg::KIND_GOOD : dfr_pkg::KIND_BAD_CRC;
				r.command_code = cmd_latch;
				r.payload_length = frame_len;
				phase = RX_SYNC1;
			end
			default: begin
				emit = sync_step(b, sync_first, RX_SYNC2);
				r.kind = dfr_pkg::KIND_BAD_SYNC;
			end
		endcase
		if (emit)
			pending_results.push_back(r);
	endtask

	task automatic check_result();
		frame_result_t want;
		if (pending_results.size() == 0) begin
			report("result with nothing pending, kind", m_tuser, 0);
		end else begin
			want = pending_results.pop_front();
			if (m_tuser != want.kind)
				report("result_kind", m_tuser, want.kind);
			if (m_tdata[7:0] != want.payload_byte)
				report("payload_byte", m_tdata[7:0], want.payload_byte);
			if (m_tdata[15:8] != want.command_code)
				report("command_code", m_tdata[15:8], want.command_code);
			if (m_tdata[31:16] != want.payload_length)
				report("payload_length", m_tdata[31:16], want.payload_length);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first = dfr_pkg::SYNC_FIRST_RST;
			sync_second = dfr_pkg::SYNC_SECOND_RST;
			sync_third = dfr_pkg::SYNC_THIRD_RST;
			phase = RX_SYNC1;
			frame_len = '0;
			byte_cnt = '0;
			cmd_latch = '0;
			crc_acc = dfr_pkg::CRC_INIT;
			crc_rx = '0;
			pending_results.delete();
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dfr_pkg::CFG_SYNC_FIRST:  sync_first = cfg_data;
					dfr_pkg::CFG_SYNC_SECOND: sync_second = cfg_data;
					dfr_pkg::CFG_SYNC_THIRD:  sync_third = cfg_data;
					default: ;
				endcase
			end
			// byte first: a result shown in the same cycle as its byte would pop its own entry
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_result();
			if (end_check && pending_results.size() != 0)
				report("results never delivered, count", pending_results.size(), 0);
			results_due <= pending_results.size();
		end
	end

endmodule

// ----- tb/tb_sync_framed_packet_crc32_deframer_unit.sv -----
// Testbench top for the packet deframer: clock, reset, sync-word settings and byte
// stimulus with random gaps and result stalls; verdict from dfr_frame_checker.
// Depends on dfr_pkg, dfr_tb_pkg and the deframer RTL.

module tb_sync_framed_packet_crc32_deframer_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_BYTES    = 320;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = dfr_pkg::CFG_SYNC_FIRST;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        end_check = 1'b0;
	int          results_due;
	int          fail_count;

	logic [7:0]  sync_a = dfr_pkg::SYNC_FIRST_RST;
	logic [7:0]  sync_b = dfr_pkg::SYNC_SECOND_RST;
	logic [7:0]  sync_c = dfr_pkg::SYNC_THIRD_RST;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	int          rx_stall_left = 0;
	int          rx_mode_left = 0;
	int          bytes_sent = 0;

	sync_framed_packet_crc32_deframer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	dfr_frame_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.end_check  (end_check),
		.results_due(results_due),
		.fail_count (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, some short, a few long.
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 16));
		if (r < 95)
			return 16'($urandom_range(17, 64));
		return 16'($urandom_range(200, 300));
	endfunction

	// Result-side back-pressure, with calm stretches of steady ready.
	always @(posedge clk) begin
		int n;
		if (rx_mode_left == 0) begin
			rx_calm = ($urandom_range(0, 3) == 0);
			rx_mode_left = $urandom_range(20, 300);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left--;
		end else if (rx_calm) begin
			m_tready <= 1'b1;
		end else begin
			n = rand_gap();
			m_tready <= (n == 0);
			if (n > 0)
				rx_stall_left = n - 1;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Called at a clock edge; returns at the edge where the byte transfer happens.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_calm ? 0 : rand_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// fixed_byte < 0 gives random payload bytes.
	task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
			input bit corrupt, input int fixed_byte);
		logic [31:0] crc;
		logic [7:0]  b;
		send_byte(sync_a);
		send_byte(sync_b);
		send_byte(sync_c);
		send_byte(cmd);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		crc = dfr_pkg::CRC_INIT;
		for (int i = 0; i < int'(len); i++) begin
			b = (fixed_byte < 0) ? 8'($urandom) : 8'(fixed_byte);
			crc = dfr_tb_pkg::crc32_update(crc, b);
			send_byte(b);
		end
		crc = ~crc;
		if (corrupt)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int k = 0; k < 4; k++)
			send_byte(crc[8*k +: 8]);
	endtask

	// good_prefix correct sync bytes, then one that breaks the word
	task automatic send_bad_sync(input int good_prefix);
		logic [7:0] want;
		logic [7:0] b;
		if (good_prefix > 0)
			send_byte(sync_a);
		if (good_prefix > 1)
			send_byte(sync_b);
		want = (good_prefix == 0) ? sync_a : (good_prefix == 1) ? sync_b : sync_c;
		b = 8'($urandom);
		while (b == want)
			b = 8'($urandom);
		send_byte(b);
	endtask

	// Line noise while hunting; never the first sync byte, so the hunt stays put.
	task automatic send_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			while (b == sync_a)
				b = 8'($urandom);
			send_byte(b);
		end
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_syncs(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		cfg_we <= 1'b1;
		cfg_index <= dfr_pkg::CFG_SYNC_FIRST;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= dfr_pkg::CFG_SYNC_SECOND;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= dfr_pkg::CFG_SYNC_THIRD;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sync_a = a;
		sync_b = b;
		sync_c = c;
	endtask

	initial begin
		int r;
		int phase_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wrong first sync, empty good frame, one-byte bad-CRC frame,
		// wrong second and third sync bytes.
		send_byte(8'h00);
		send_frame(8'hFF, 16'd0, 1'b0, -1);
		send_frame(8'h00, 16'd1, 1'b1, 8'h00);
		send_bad_sync(1);
		send_bad_sync(2);
		wait_quiet();

		for (int p = 0; p < 5; p++) begin
			case (p)
				1: write_syncs(8'h00, 8'h00, 8'h00);
				2: write_syncs(8'hFF, 8'hFF, 8'hFF);
				3: write_syncs(8'($urandom), 8'($urandom), 8'($urandom));
				4: write_syncs(dfr_pkg::SYNC_FIRST_RST, dfr_pkg::SYNC_SECOND_RST,
						dfr_pkg::SYNC_THIRD_RST);
				default: ;
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				tx_calm = ($urandom_range(0, 4) == 0);
				r = $urandom_range(0, 99);
				if (r < 70)
					send_frame(8'($urandom), pick_len(), $urandom_range(0, 4) == 0, -1);
				else if (r < 85)
					send_bad_sync($urandom_range(0, 2));
				else
					send_noise($urandom_range(1, 4));
				if ($urandom_range(0, 19) == 0)
					wait_quiet();
			end
			wait_quiet();
		end

		end_check <= 1'b1;
		@(posedge clk);
		end_check <= 1'b0;
		@(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/dfr_pkg.sv
src/dfr_in_reg.sv
src/dfr_parser.sv
src/dfr_out_reg.sv
src/sync_framed_packet_crc32_deframer_unit.sv
src/dfr_checker.sv
tb/dfr_frame_checker.sv
tb/tb_sync_framed_packet_crc32_deframer_unit.sv
